// ===== hdl/utrd_pkg.sv =====
// types, constants and helpers shared by the radix digit converter
package utrd_pkg;

  localparam int RADIX_W  = 6;
  localparam int DIGIT_W  = 6;
  localparam int CHAR_W   = 7;
  localparam int COUNT_W  = 7;
  localparam int INPUT_W  = 64;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd16;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

  localparam logic [DIGIT_W-1:0] DEC_BASE   = 6'd10;
  localparam logic [CHAR_W-1:0]  ASCII_ZERO = 7'd48;
  localparam logic [CHAR_W-1:0]  ASCII_A    = 7'd65;

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SKIP = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {1'b0, d};
    if (d < DEC_BASE) begin
      digit_to_ascii = ASCII_ZERO + dx;
    end else begin
      digit_to_ascii = ASCII_A - {1'b0, DEC_BASE} + dx;
    end
  endfunction

endpackage

// ===== hdl/utrd_cell.sv =====
// one digit cell: clears, doubles its digit plus carry modulo radix, or shifts from its neighbor
module utrd_cell import utrd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cell_ctl_t          ctl,
  input  logic [RADIX_W-1:0] radix,
  input  logic [DIGIT_W-1:0] shift_in,
  input  logic               carry_in,
  input  logic               act_in,
  output logic [DIGIT_W-1:0] digit,
  output logic               carry_out,
  output logic               act_out
);

  logic [DIGIT_W-1:0] digit_r, digit_nxt;
  logic               carry_r, carry_nxt;
  logic               act_r, act_nxt;
  logic [DIGIT_W:0]   dbl;
  logic [DIGIT_W:0]   red;
  logic               ge;

  always_comb begin
    dbl = {digit_r, carry_in};
    red = dbl - {1'b0, radix};
    ge  = (dbl >= {1'b0, radix});
  end

  always_comb begin
    digit_nxt = digit_r;
    carry_nxt = 1'b0;
    act_nxt   = 1'b0;
    priority if (ctl.clear) begin
      digit_nxt = '0;
    end else if (ctl.shift) begin
      digit_nxt = shift_in;
    end else if (act_in) begin
      digit_nxt = ge ? red[DIGIT_W-1:0] : dbl[DIGIT_W-1:0];
      carry_nxt = ge;
      act_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_r <= 1'b0;
      act_r   <= 1'b0;
    end else begin
      carry_r <= carry_nxt;
      act_r   <= act_nxt;
    end
  end

  assign digit     = digit_r;
  assign carry_out = carry_r;
  assign act_out   = act_r;

endmodule

// ===== hdl/unsigned_to_radix_digits.sv =====
// top level: unsigned value to ascii digits in a configured radix, msd first
//
//   channel | ports                                    | direction
//   --------+------------------------------------------+----------
//   in      | in_valid, in_stall, in_value             | item in
//   out     | out_valid, out_stall, out_digit_char,    | one item per digit
//           | out_last, out_digit_count                |
//   cfg     | cfg_we, cfg_wdata                        | radix write
//
// conversion: value bits enter the cell row msb first and ripple through it
// then leading zero skip, then output of the digits, which waits while out_stall is high
// one item at a time; the next item is accepted only after the last digit is taken
// synchronous active-low reset, radix resets to sixteen
// out stall holds the current digit, in_stall is high whenever not idle
module unsigned_to_radix_digits import utrd_pkg::*; #(
  parameter int VALUE_BITS = 64,
  parameter int MAX_DIGITS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [INPUT_W-1:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [CHAR_W-1:0]  out_digit_char,
  output logic               out_last,
  output logic [COUNT_W-1:0] out_digit_count,
  input  logic               cfg_we,
  input  logic [RADIX_W-1:0] cfg_wdata
);

  localparam int CNT_W = $clog2(VALUE_BITS + MAX_DIGITS);
  localparam int REM_W = $clog2(MAX_DIGITS + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_BITS + MAX_DIGITS - 2);
  localparam logic [CNT_W-1:0] CNT_FEED = CNT_W'(VALUE_BITS);
  localparam logic [REM_W-1:0] REM_FULL = REM_W'(MAX_DIGITS);
  localparam logic [REM_W-1:0] REM_ONE  = REM_W'(1);

  state_t                  state_r, state_nxt;
  logic [RADIX_W-1:0]      radix_r, radix_nxt;
  logic [VALUE_BITS-1:0]   val_r, val_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [REM_W-1:0]        rem_r, rem_nxt;
  logic [REM_W-1:0]        count_r, count_nxt;

  cell_ctl_t               ctl;
  logic                    in_acc, out_acc;
  logic [DIGIT_W-1:0]      top_digit;

  logic [DIGIT_W-1:0]      digit_chain [MAX_DIGITS+1];
  logic                    carry_chain [MAX_DIGITS+1];
  logic                    act_chain   [MAX_DIGITS+1];

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;
  assign top_digit = digit_chain[MAX_DIGITS];

  assign digit_chain[0] = '0;
  assign carry_chain[0] = val_r[VALUE_BITS-1];
  assign act_chain[0]   = (state_r == ST_CONV) && (cnt_r < CNT_FEED);

  for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
    utrd_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .radix     (radix_r),
      .shift_in  (digit_chain[i]),
      .carry_in  (carry_chain[i]),
      .act_in    (act_chain[i]),
      .digit     (digit_chain[i+1]),
      .carry_out (carry_chain[i+1]),
      .act_out   (act_chain[i+1])
    );
  end

  always_comb begin
    radix_nxt = radix_r;
    if (cfg_we) begin
      priority if (cfg_wdata < RADIX_MIN) begin
        radix_nxt = RADIX_MIN;
      end else if (cfg_wdata > RADIX_MAX) begin
        radix_nxt = RADIX_MAX;
      end else begin
        radix_nxt = cfg_wdata;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    val_nxt   = val_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    count_nxt = count_r;
    ctl       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ctl.clear = 1'b1;
          val_nxt   = in_value[VALUE_BITS-1:0];
          cnt_nxt   = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        val_nxt = {val_r[VALUE_BITS-2:0], 1'b0};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          rem_nxt   = REM_FULL;
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (top_digit != '0 || rem_r == REM_ONE) begin
          count_nxt = rem_r;
          state_nxt = ST_EMIT;
        end else begin
          ctl.shift = 1'b1;
          rem_nxt   = rem_r - REM_ONE;
        end
      end
      ST_EMIT: begin
        if (!out_stall) begin
          ctl.shift = 1'b1;
          rem_nxt   = rem_r - REM_ONE;
          if (rem_r == REM_ONE) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      radix_r <= RADIX_RESET;
      cnt_r   <= '0;
      rem_r   <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      radix_r <= radix_nxt;
      cnt_r   <= cnt_nxt;
      rem_r   <= rem_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign out_digit_char  = digit_to_ascii(top_digit);
  assign out_last        = (rem_r == REM_ONE);
  assign out_digit_count = COUNT_W'(count_r);

  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("result shown while input open");

  a_accept_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_CONV && cnt_r == '0))
    else $error("accepted item did not start conversion");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_last) |=> (!out_valid && !in_stall))
    else $error("run did not end after last digit");

  a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (rem_r != '0 && rem_r <= count_r))
    else $error("remaining digits out of range");

  a_row_quiet_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!act_chain[MAX_DIGITS] && !carry_chain[MAX_DIGITS]))
    else $error("cell row busy while idle");

endmodule

// ===== sim/tb_top.sv =====
// testbench for the radix digit converter: directed table, then random phases over radix settings
module tb_top;
  import utrd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TARGET_ITEMS   = 470;
  localparam int DRAIN_CYCLES   = 8;

  typedef struct packed {
    logic [CHAR_W-1:0]  digit_char;
    logic               last;
    logic [COUNT_W-1:0] digit_count;
  } digit_item_t;

  typedef struct packed {
    logic [RADIX_W-1:0] radix;
    logic [INPUT_W-1:0] value;
    logic               known;
    logic [CHAR_W-1:0]  known_char;
    logic [COUNT_W-1:0] known_count;
  } value_row_t;

  localparam int N_ROWS = 23;

  value_row_t value_rows [N_ROWS] = '{
    '{6'd16, 64'd0,                  1'b1, 7'h30, 7'd1},
    '{6'd16, 64'hffff_ffff_ffff_ffff, 1'b1, 7'h46, 7'd16},
    '{6'd16, 64'd1,                  1'b1, 7'h31, 7'd1},
    '{6'd16, 64'h0123_4567_89ab_cdef, 1'b0, 7'h00, 7'd0},
    '{6'd2,  64'hffff_ffff_ffff_ffff, 1'b1, 7'h31, 7'd64},
    '{6'd2,  64'd0,                  1'b1, 7'h30, 7'd1},
    '{6'd2,  64'h8000_0000_0000_0000, 1'b0, 7'h00, 7'd0},
    '{6'd2,  64'h5555_5555_5555_5555, 1'b0, 7'h00, 7'd0},
    '{6'd10, 64'd9,                  1'b1, 7'h39, 7'd1},
    '{6'd10, 64'd10,                 1'b0, 7'h00, 7'd0},
    '{6'd10, 64'hffff_ffff_ffff_ffff, 1'b0, 7'h00, 7'd0},
    '{6'd36, 64'd35,                 1'b1, 7'h5a, 7'd1},
    '{6'd36, 64'd36,                 1'b0, 7'h00, 7'd0},
    '{6'd36, 64'hffff_ffff_ffff_ffff, 1'b0, 7'h00, 7'd0},
    '{6'd0,  64'hffff_ffff_ffff_ffff, 1'b1, 7'h31, 7'd64},
    '{6'd1,  64'd6,                  1'b0, 7'h00, 7'd0},
    '{6'd37, 64'd35,                 1'b1, 7'h5a, 7'd1},
    '{6'd63, 64'hffff_ffff_ffff_ffff, 1'b0, 7'h00, 7'd0},
    '{6'd3,  64'hffff_ffff_ffff_ffff, 1'b0, 7'h00, 7'd0},
    '{6'd8,  64'h8000_0000_0000_0000, 1'b0, 7'h00, 7'd0},
    '{6'd35, 64'd34,                 1'b1, 7'h59, 7'd1},
    '{6'd11, 64'd10,                 1'b1, 7'h41, 7'd1},
    '{6'd16, 64'hffff_ffff_ffff_fffe, 1'b0, 7'h00, 7'd0}
  };

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [INPUT_W-1:0] in_value;
  logic               out_valid;
  logic               out_stall;
  logic [CHAR_W-1:0]  out_digit_char;
  logic               out_last;
  logic [COUNT_W-1:0] out_digit_count;
  logic               cfg_we;
  logic [RADIX_W-1:0] cfg_wdata;

  digit_item_t        expected_digits [$];
  digit_item_t        want;
  logic [RADIX_W-1:0] cur_radix;
  bit                 no_idle;
  int                 mismatch_count;
  int                 items_sent;
  int                 digits_checked;
  int                 radix_writes;
  int                 idle_cycles;

  unsigned_to_radix_digits u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digit_char  (out_digit_char),
    .out_last        (out_last),
    .out_digit_count (out_digit_count),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 40);
  endfunction

  function automatic int unsigned clamp_radix(input logic [RADIX_W-1:0] r);
    if (r < RADIX_MIN) begin
      return RADIX_MIN;
    end
    if (r > RADIX_MAX) begin
      return RADIX_MAX;
    end
    return r;
  endfunction

  // divide down by the radix, then queue the digits msd first
  function automatic void predict_digits(input logic [INPUT_W-1:0] v);
    logic [INPUT_W-1:0] q;
    logic [DIGIT_W-1:0] rems [64];
    logic [DIGIT_W-1:0] d;
    int unsigned        base;
    int                 n;
    int                 k;
    digit_item_t        e;
    base = clamp_radix(cur_radix);
    q = v;
    n = 0;
    do begin
      rems[n] = DIGIT_W'(q % base);
      n++;
      q = q / base;
    end while (q != 0 && n < 64);
    for (k = 0; k < n; k++) begin
      d = rems[n - 1 - k];
      if (d < DEC_BASE) begin
        e.digit_char = ASCII_ZERO + CHAR_W'(d);
      end else begin
        e.digit_char = ASCII_A + CHAR_W'(d) - CHAR_W'(DEC_BASE);
      end
      e.last = (k == n - 1);
      e.digit_count = COUNT_W'(n);
      expected_digits.push_back(e);
    end
  endfunction

  function automatic void push_known(input logic [CHAR_W-1:0] c, input logic [COUNT_W-1:0] cnt);
    digit_item_t e;
    int          k;
    for (k = 0; k < cnt; k++) begin
      e.digit_char = c;
      e.last = (k == cnt - 1);
      e.digit_count = cnt;
      expected_digits.push_back(e);
    end
  endfunction

  function automatic logic [INPUT_W-1:0] random_value();
    logic [INPUT_W-1:0] p;
    logic [INPUT_W-1:0] base;
    int                 kind;
    int                 k;
    kind = $urandom_range(0, 9);
    case (kind)
      0: begin
        return INPUT_W'($urandom_range(0, 40));
      end
      1: begin
        return '1;
      end
      2: begin
        return INPUT_W'(1) << $urandom_range(0, 63);
      end
      3: begin
        return {$urandom, $urandom} >> $urandom_range(0, 63);
      end
      4: begin
        base = INPUT_W'(clamp_radix(cur_radix));
        p = 1;
        k = $urandom_range(1, 64);
        repeat (k) begin
          if (p <= 64'hffff_ffff_ffff_ffff / base) begin
            p = p * base;
          end
        end
        return p - INPUT_W'($urandom_range(0, 1));
      end
      default: begin
        return {$urandom, $urandom};
      end
    endcase
  endfunction

  task automatic send_value(input logic [INPUT_W-1:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic write_radix(input logic [RADIX_W-1:0] r);
    in_valid <= 1'b0;
    while (expected_digits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_radix = r;
    radix_writes++;
  endtask

  // result side: random stall bursts
  initial begin
    int gap;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
        out_stall <= 1'b0;
      end
      repeat ($urandom_range(0, 6)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout with %0d digits outstanding", expected_digits.size());
        $display("end of test: mismatches");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (expected_digits.size() == 0) begin
          $error("unexpected item: digit_char %0d last %0d digit_count %0d",
                 out_digit_char, out_last, out_digit_count);
          mismatch_count++;
        end else begin
          want = expected_digits.pop_front();
          digits_checked++;
          if (out_digit_char !== want.digit_char) begin
            $error("digit_char expected %0d actual %0d", want.digit_char, out_digit_char);
            mismatch_count++;
          end
          if (out_last !== want.last) begin
            $error("last expected %0d actual %0d", want.last, out_last);
            mismatch_count++;
          end
          if (out_digit_count !== want.digit_count) begin
            $error("digit_count expected %0d actual %0d", want.digit_count, out_digit_count);
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin
    logic [RADIX_W-1:0] extremes [8];
    int                 i;
    int                 phase;
    int                 n;
    logic [INPUT_W-1:0] v;
    extremes = '{6'd0, 6'd1, 6'd2, 6'd36, 6'd37, 6'd63, 6'd16, 6'd10};
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_value <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    no_idle = 1'b0;
    mismatch_count = 0;
    items_sent = 0;
    digits_checked = 0;
    radix_writes = 0;
    cur_radix = RADIX_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < N_ROWS; i++) begin
      if (value_rows[i].radix != cur_radix) begin
        write_radix(value_rows[i].radix);
      end
      send_value(value_rows[i].value);
      if (value_rows[i].known) begin
        push_known(value_rows[i].known_char, value_rows[i].known_count);
      end else begin
        predict_digits(value_rows[i].value);
      end
    end

    phase = 0;
    while (items_sent < TARGET_ITEMS) begin
      write_radix(phase < 8 ? extremes[phase] : RADIX_W'($urandom_range(0, 63)));
      no_idle = ($urandom_range(0, 4) == 0);
      n = $urandom_range(15, 35);
      repeat (n) begin
        v = random_value();
        send_value(v);
        predict_digits(v);
      end
      phase++;
    end
    no_idle = 1'b0;

    in_valid <= 1'b0;
    while (expected_digits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d values converted, %0d digits checked", items_sent, digits_checked);
    $display("%0d radix writes, covering bases 2 to 36 and clamped settings on both ends",
             radix_writes);
    if (mismatch_count == 0 && expected_digits.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
